// ===== hw/rtl/m3i_pkg.sv =====
// Package for the 3x3 matrix inverse: word types, widths and cofactor index tables.
// Used by matrix3x3_inverse. Depends on nothing else.
`default_nettype none
package m3i_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DW        = 32;
    localparam int NEL       = 9;
    localparam int PW        = 2 * DW;
    localparam int CW        = 2 * DW + 1;
    localparam int DETW      = 3 * DW + 1;
    localparam int NUMW0     = 2 * DW + 2 * FRAC_BITS + 1;
    localparam int NUMW      = ((NUMW0 > DETW) ? NUMW0 : DETW) + 1;
    localparam int THRW      = DW - 1;
    localparam int QBITS     = DW + 2;
    localparam int LATENCY   = 7 + QBITS + 1;

    localparam logic [3:0] CF_P [0:8] = '{4'd4, 4'd2, 4'd1, 4'd5, 4'd0, 4'd2, 4'd3, 4'd1, 4'd0};
    localparam logic [3:0] CF_Q [0:8] = '{4'd8, 4'd7, 4'd5, 4'd6, 4'd8, 4'd3, 4'd7, 4'd6, 4'd4};
    localparam logic [3:0] CF_R [0:8] = '{4'd5, 4'd1, 4'd2, 4'd3, 4'd2, 4'd0, 4'd4, 4'd0, 4'd1};
    localparam logic [3:0] CF_S [0:8] = '{4'd7, 4'd8, 4'd4, 4'd8, 4'd6, 4'd5, 4'd6, 4'd7, 4'd3};

    typedef struct packed {
        logic signed [DW-1:0] a00;
        logic signed [DW-1:0] a01;
        logic signed [DW-1:0] a02;
        logic signed [DW-1:0] a10;
        logic signed [DW-1:0] a11;
        logic signed [DW-1:0] a12;
        logic signed [DW-1:0] a20;
        logic signed [DW-1:0] a21;
        logic signed [DW-1:0] a22;
    } t_mat_in;

    typedef struct packed {
        logic signed [DW-1:0] r00;
        logic signed [DW-1:0] r01;
        logic signed [DW-1:0] r02;
        logic signed [DW-1:0] r10;
        logic signed [DW-1:0] r11;
        logic signed [DW-1:0] r12;
        logic signed [DW-1:0] r20;
        logic signed [DW-1:0] r21;
        logic signed [DW-1:0] r22;
        logic                 invertible;
    } t_res;

endpackage
`default_nettype wire

// ===== hw/rtl/matrix3x3_inverse.sv =====
// Top level of the 3x3 matrix inverse: cofactors, determinant and a pipelined divider.
// Depends on m3i_pkg.
//
// Channel   Direction  Handshake             Word
// matrix    in         start, busy           i_mat (t_mat_in)
// result    out        o_strobe              o_res (t_res)
// config    in         i_cfg_we              i_cfg_wdata (determinant threshold)
//
// A matrix is taken in every cycle and busy is never raised.
// Each result is formed by the cofactor and determinant stages and the 34-stage restoring divider.
// Reset clears the valid bits and sets the threshold to one.
// The receiver cannot stall, so nothing in the pipeline ever waits.
`default_nettype none
module matrix3x3_inverse (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire m3i_pkg::t_mat_in         i_mat,
    input  wire logic                     i_cfg_we,
    input  wire logic [m3i_pkg::THRW-1:0] i_cfg_wdata,
    output logic                          o_strobe,
    output m3i_pkg::t_res                 o_res
);
    import m3i_pkg::*;

    logic [THRW-1:0] r_thr;

    logic signed [DW-1:0]   w_a       [0:8];
    logic signed [PW-1:0]   n_p1_m    [0:17];
    logic signed [PW-1:0]   r_p1_m    [0:17];
    logic signed [CW-1:0]   n_p2_c    [0:8];
    logic signed [CW-1:0]   r_p2_c    [0:8];
    logic signed [CW-1:0]   r_p3_c    [0:8];
    logic signed [CW-1:0]   r_p4_c    [0:8];
    logic signed [CW:0]     n_p3_pl   [0:2];
    logic signed [CW:0]     n_p3_ph   [0:2];
    logic signed [CW:0]     r_p3_pl   [0:2];
    logic signed [CW:0]     r_p3_ph   [0:2];
    logic signed [DETW-1:0] r_p4_t    [0:2];
    logic signed [DETW-1:0] r_p5_det;
    logic [PW-1:0]          r_p5_cabs [0:8];
    logic [PW-1:0]          r_p6_cabs [0:8];
    logic [NEL-1:0]         r_p5_cneg;
    logic [NEL-1:0]         r_p6_cneg;
    logic [DETW-1:0]        r_p6_mdet;
    logic                   r_p6_dneg;
    logic                   r_p6_inv;
    logic [DETW-1:0]        w_thr;
    logic [DETW-1:0]        w_mdet;
    t_mat_in                r_src [1:6];
    logic                   r_vld [1:6];

    logic [NUMW-1:0]  r_dv_rem [0:QBITS][0:8];
    logic [QBITS-1:0] r_dv_q   [0:QBITS][0:8];
    logic [NUMW-1:0]  r_dv_den [0:QBITS];
    logic [NEL-1:0]   r_dv_neg [0:QBITS];
    logic             r_dv_inv [0:QBITS];
    t_mat_in          r_dv_src [0:QBITS];
    logic             r_dv_vld [0:QBITS];
    logic [NUMW-1:0]  n_dv_rem [1:QBITS][0:8];
    logic [QBITS-1:0] n_dv_q   [1:QBITS][0:8];

    logic [DW-1:0] w_r [0:8];
    t_res          n_out;
    t_res          r_out;
    logic          r_out_vld;
    logic          w_rem_ok;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THRW'(1);
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_wdata;
        end
    end

    function automatic logic signed [DW-1:0] w_a_p2(input int k);
        logic [NEL*DW-1:0] v;
        v = r_src[2];
        return v[(NEL-1-k)*DW +: DW];
    endfunction

    always_comb begin
        for (int i = 0; i < NEL; i++) begin
            w_a[i] = i_mat[(NEL-1-i)*DW +: DW];
        end
        for (int i = 0; i < NEL; i++) begin
            n_p1_m[2*i]   = w_a[CF_P[i]] * w_a[CF_Q[i]];
            n_p1_m[2*i+1] = w_a[CF_R[i]] * w_a[CF_S[i]];
        end
        for (int i = 0; i < NEL; i++) begin
            n_p2_c[i] = CW'(r_p1_m[2*i]) - CW'(r_p1_m[2*i+1]);
        end
        for (int i = 0; i < 3; i++) begin
            n_p3_pl[i] = w_a_p2(i) * $signed({1'b0, r_p2_c[3*i][DW-1:0]});
            n_p3_ph[i] = w_a_p2(i) * $signed(r_p2_c[3*i][CW-1:DW]);
        end
        w_thr  = DETW'(r_thr) << (2 * FRAC_BITS);
        w_mdet = r_p5_det[DETW-1] ? DETW'(-r_p5_det) : DETW'(r_p5_det);
    end

    always_ff @(posedge i_clk) begin
        r_src[1] <= i_mat;
        r_p1_m   <= n_p1_m;
        r_src[2] <= r_src[1];
        r_p2_c   <= n_p2_c;
        r_src[3] <= r_src[2];
        r_p3_c   <= r_p2_c;
        r_p3_pl  <= n_p3_pl;
        r_p3_ph  <= n_p3_ph;
        r_src[4] <= r_src[3];
        r_p4_c   <= r_p3_c;
        for (int i = 0; i < 3; i++) begin
            r_p4_t[i] <= (DETW'(r_p3_ph[i]) <<< DW) + DETW'(r_p3_pl[i]);
        end
        r_src[5] <= r_src[4];
        r_p5_det <= r_p4_t[0] + r_p4_t[1] + r_p4_t[2];
        for (int i = 0; i < NEL; i++) begin
            r_p5_cneg[i] <= r_p4_c[i][CW-1];
            r_p5_cabs[i] <= r_p4_c[i][CW-1] ? PW'(-r_p4_c[i]) : PW'(r_p4_c[i]);
        end
        r_src[6]  <= r_src[5];
        r_p6_cabs <= r_p5_cabs;
        r_p6_cneg <= r_p5_cneg;
        r_p6_mdet <= w_mdet;
        r_p6_dneg <= r_p5_det[DETW-1];
        r_p6_inv  <= w_mdet > w_thr;
        r_dv_src[0] <= r_src[6];
        r_dv_inv[0] <= r_p6_inv;
        r_dv_den[0] <= NUMW'(r_p6_mdet) << 1;
        for (int i = 0; i < NEL; i++) begin
            r_dv_rem[0][i] <= (NUMW'(r_p6_cabs[i]) << (2 * FRAC_BITS + 1)) + NUMW'(r_p6_mdet);
            r_dv_q[0][i]   <= '0;
            r_dv_neg[0][i] <= r_p6_cneg[i] ^ r_p6_dneg;
        end
        for (int j = 1; j <= QBITS; j++) begin
            r_dv_src[j] <= r_dv_src[j-1];
            r_dv_inv[j] <= r_dv_inv[j-1];
            r_dv_den[j] <= r_dv_den[j-1];
            r_dv_neg[j] <= r_dv_neg[j-1];
            for (int i = 0; i < NEL; i++) begin
                r_dv_rem[j][i] <= n_dv_rem[j][i];
                r_dv_q[j][i]   <= n_dv_q[j][i];
            end
        end
        r_out <= n_out;
    end

    always_comb begin
        for (int j = 1; j <= QBITS; j++) begin
            for (int i = 0; i < NEL; i++) begin
                n_dv_rem[j][i] = r_dv_rem[j-1][i];
                n_dv_q[j][i]   = r_dv_q[j-1][i];
                if ((r_dv_rem[j-1][i] >> (QBITS - j)) >= r_dv_den[j-1]) begin
                    n_dv_rem[j][i] = r_dv_rem[j-1][i] - (r_dv_den[j-1] << (QBITS - j));
                    n_dv_q[j][i][QBITS-j] = 1'b1;
                end
            end
        end
    end

    always_comb begin
        logic [QBITS-1:0] q;
        logic             big;
        logic [NEL*DW-1:0] src;
        src = r_dv_src[QBITS];
        for (int i = 0; i < NEL; i++) begin
            q   = r_dv_q[QBITS][i];
            big = q[QBITS-1] | q[QBITS-2];
            if (!r_dv_inv[QBITS]) begin
                w_r[i] = src[(NEL-1-i)*DW +: DW];
            end else if (r_dv_neg[QBITS][i]) begin
                if (big || (q[DW-1] && (q[DW-2:0] != '0))) begin
                    w_r[i] = {1'b1, {(DW-1){1'b0}}};
                end else begin
                    w_r[i] = -q[DW-1:0];
                end
            end else begin
                if (big || q[DW-1]) begin
                    w_r[i] = {1'b0, {(DW-1){1'b1}}};
                end else begin
                    w_r[i] = q[DW-1:0];
                end
            end
        end
        n_out = {w_r[0], w_r[1], w_r[2], w_r[3], w_r[4], w_r[5], w_r[6], w_r[7], w_r[8],
                 r_dv_inv[QBITS]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 1; s <= 6; s++) begin
                r_vld[s] <= 1'b0;
            end
            for (int j = 0; j <= QBITS; j++) begin
                r_dv_vld[j] <= 1'b0;
            end
            r_out_vld <= 1'b0;
        end else begin
            r_vld[1] <= start & ~busy;
            for (int s = 2; s <= 6; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
            r_dv_vld[0] <= r_vld[6];
            for (int j = 1; j <= QBITS; j++) begin
                r_dv_vld[j] <= r_dv_vld[j-1];
            end
            r_out_vld <= r_dv_vld[QBITS];
        end
    end

    assign o_strobe = r_out_vld;
    assign o_res    = r_out;

    always_comb begin
        w_rem_ok = 1'b1;
        for (int i = 0; i < NEL; i++) begin
            if (!r_dv_q[QBITS][i][QBITS-1] && (r_dv_rem[QBITS][i] >= r_dv_den[QBITS])) begin
                w_rem_ok = 1'b0;
            end
        end
    end

    a_word_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LATENCY o_strobe)
        else $error("accepted word produced no result");
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(start && !busy) |-> ##LATENCY !o_strobe)
        else $error("result without an accepted word");
    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dv_vld[0] && r_dv_inv[0]) |-> (r_dv_den[0] != '0))
        else $error("divider started with zero divisor");
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dv_vld[QBITS] && r_dv_inv[QBITS]) |-> w_rem_ok)
        else $error("divider remainder not below divisor");

endmodule
`default_nettype wire
